/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever trig holds, cond holds too.
`define RBCA_ASSERT_SAME(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever trig holds, cond holds in the next cycle.
`define RBCA_ASSERT_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* src/rbca_pkg.sv */
// ----------------------------------------------------------------------------
// rbca_pkg
// Shared constants, register codes and types of the RGB brightness/contrast
// adjuster.
// ----------------------------------------------------------------------------
`default_nettype none

package rbca_pkg;

   // channel format
   localparam int unsigned CH_BITS     = 8;
   localparam int unsigned CH_MAX      = (1 << CH_BITS) - 1;
   localparam int unsigned CH_MID      = 1 << (CH_BITS - 1);
   localparam int unsigned PIX_BITS    = 3 * CH_BITS;

   // pipeline depth of the pixel path
   localparam int unsigned PIPE_STAGES = 3;

   // default coefficient fraction width (Q8.16)
   localparam int unsigned COEF_FRAC_BITS_DEF = 16;

   // contrast formula constants
   localparam int unsigned CONTRAST_K  = 259;
   localparam int unsigned SCALE_255   = 255;
   localparam int unsigned MANT_BITS   = 18;   // 259 * 510 < 2^18
   localparam int unsigned DEN_BITS    = 18;   // 255 * 514 < 2^18

   // configuration port
   localparam int unsigned CSR_IDX_BITS  = 4;
   localparam int unsigned CSR_DATA_BITS = 8;
   localparam int unsigned MODE_BITS     = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE      = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INTENSITY = 4'd1;

   // mode encoding: bit 0 selects lowering, bit 1 selects contrast
   localparam logic [MODE_BITS-1:0] MODE_BRIGHT_UP   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_BRIGHT_DOWN = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CONTRAST_UP = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_CONTRAST_DN = 2'd3;
   localparam int unsigned MODE_LOWER_BIT    = 0;
   localparam int unsigned MODE_CONTRAST_BIT = 1;

   // coefficient recompute request from the register file to the divider
   typedef struct packed {
      logic               start;
      logic               lower;
      logic [CH_BITS-1:0] level;
   } coef_req_type;

endpackage

`default_nettype wire

/* src/rgb_brightness_contrast_adjust.sv */
// Usage:
// Pixels enter on the req_ stream (tdata = red, green, blue from bit 0 up)
// and leave on the rsp_ stream in the same packing, one result per request.
// The pixel path is a 3-stage pipeline with a valid bit per stage; a request
// accepted on req_ moves through the stage registers in order to rsp_.
// Throughput is one pixel per cycle; each stage holds while the stage after
// it is full and stalled, so a stalled receiver backs up into req_tready
// without losing or repeating a pixel, and empty stages keep filling.
// Registers are written over csr_: index 0 mode, index 1 intensity. Each
// accepted write to a known index recomputes the contrast coefficient in a
// bit-serial divider: a start pulse, then 18 + COEF_FRAC_BITS steps, during
// which req_tready and csr_ready are low. csr_ready also waits for the pixel
// pipeline to be empty, and req_tready stays low while csr_valid is high, so
// settings never change mid-flight.
// Reset clears mode and intensity to 0, sets the coefficient to 1.0 and
// empties the pipeline.
// ----------------------------------------------------------------------------
// rgb_brightness_contrast_adjust
// Top level: stream handshake, stage valid bits, registers, three channel
// datapaths and the coefficient divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rgb_brightness_contrast_adjust
   import rbca_pkg::*;
#(
   parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request stream
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [PIX_BITS-1:0]       req_tdata,   // red_in, green_in, blue_in
   // result stream
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [PIX_BITS-1:0]            rsp_tdata,   // red_out, green_out, blue_out
   // register writes
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int unsigned CW = CH_BITS + COEF_FRAC_BITS;

   logic [MODE_BITS-1:0]   mode_ff, mode_in;
   logic [CH_BITS-1:0]     intensity_ff, intensity_in;
   logic                   start_ff, start_in;
   logic [PIPE_STAGES-1:0] vld_ff, vld_in;
   logic [PIPE_STAGES-1:0] en;

   logic                   csr_fire;
   logic                   csr_known;
   logic                   req_fire;
   logic                   coef_busy;
   logic                   cfg_busy;
   logic [CW-1:0]          coef;
   coef_req_type           coef_req;

   // register writes, only with the pipeline empty, then one divider start
   assign cfg_busy  = start_ff | coef_busy;
   assign csr_ready = ~cfg_busy & ~(|vld_ff);
   assign csr_fire  = csr_valid & csr_ready;
   assign csr_known = (csr_index == CSR_MODE) || (csr_index == CSR_INTENSITY);

   always_comb begin
      mode_in      = mode_ff;
      intensity_in = intensity_ff;
      start_in     = 1'b0;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_MODE: begin
               mode_in  = csr_wdata[MODE_BITS-1:0];
               start_in = 1'b1;
            end
            CSR_INTENSITY: begin
               intensity_in = csr_wdata[CH_BITS-1:0];
               start_in     = 1'b1;
            end
            default: begin
               start_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BRIGHT_UP;
         intensity_ff <= '0;
         start_ff     <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         intensity_ff <= intensity_in;
         start_ff     <= start_in;
      end
   end

   assign coef_req.start = start_ff;
   assign coef_req.lower = mode_ff[MODE_LOWER_BIT];
   assign coef_req.level = intensity_ff;

   rbca_coef_div #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_coef_div (
      .clock (clock),
      .reset (reset),
      .req   (coef_req),
      .coef  (coef),
      .busy  (coef_busy)
   );

   // stage enables: a stage loads when empty or when the next one moves
   always_comb begin
      en[PIPE_STAGES-1] = ~vld_ff[PIPE_STAGES-1] | rsp_tready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         en[i] = ~vld_ff[i] | en[i+1];
      end
   end

   // a pending register write keeps new pixels out
   assign req_tready = en[0] & ~cfg_busy & ~csr_valid;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      vld_in[0] = en[0] ? req_fire : vld_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // one datapath per channel
   for (genvar c = 0; c < 3; c++) begin : g_chan
      rbca_chan_map #(
         .COEF_FRAC_BITS(COEF_FRAC_BITS)
      ) u_chan (
         .clock   (clock),
         .en      (en),
         .mode    (mode_ff),
         .level   (intensity_ff),
         .coef    (coef),
         .pix_in  (req_tdata[c*CH_BITS +: CH_BITS]),
         .pix_out (rsp_tdata[c*CH_BITS +: CH_BITS])
      );
   end

   assign rsp_tvalid = vld_ff[PIPE_STAGES-1];

   // no pixel enters while the coefficient is being rebuilt
   `RBCA_ASSERT_SAME(a_no_req_while_div, req_fire, !coef_busy && !start_ff)
   // a write to a known register always starts a recompute
   `RBCA_ASSERT_NEXT(a_write_starts_div, csr_fire && csr_known, start_ff)
   // the divider is running in the cycle after its start pulse
   `RBCA_ASSERT_NEXT(a_div_runs, start_ff, coef_busy)

endmodule

`default_nettype wire

/* src/rbca_coef_div.sv */
// ----------------------------------------------------------------------------
// rbca_coef_div
// Contrast coefficient unit: builds numerator and denominator from the
// intensity, then runs a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbca_coef_div
   import rbca_pkg::*;
#(
   parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire coef_req_type                       req,
   output logic [CH_BITS+COEF_FRAC_BITS-1:0]       coef,
   output logic                                    busy
);

   localparam int unsigned CW    = CH_BITS + COEF_FRAC_BITS;
   localparam int unsigned NUM_W = MANT_BITS + COEF_FRAC_BITS;
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [CW-1:0]       quo_ff, quo_in;
   logic [CW-1:0]       coef_ff, coef_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic [CH_BITS:0]    mant_arg;
   logic [CH_BITS+1:0]  den_arg;     // 259 + 255 needs ten bits
   logic [MANT_BITS-1:0] mant;
   logic [DEN_BITS-1:0] den_start;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                fits;

   // operands: raise 259*(k+255) / 255*(259-k), lower 259*(255-k) / 255*(259+k)
   always_comb begin
      if (req.lower) begin
         mant_arg = (CH_BITS+1)'(SCALE_255) - {1'b0, req.level};
         den_arg  = (CH_BITS+2)'(CONTRAST_K) + {2'b0, req.level};
      end else begin
         mant_arg = (CH_BITS+1)'(SCALE_255) + {1'b0, req.level};
         den_arg  = (CH_BITS+2)'(CONTRAST_K) - {2'b0, req.level};
      end
      mant      = MANT_BITS'(CONTRAST_K) * MANT_BITS'(mant_arg);
      den_start = DEN_BITS'(SCALE_255) * DEN_BITS'(den_arg);
   end

   // one restoring step
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      coef_in = coef_ff;
      cnt_in  = cnt_ff;
      if (req.start) begin
         num_in = {mant, {COEF_FRAC_BITS{1'b0}}};
         den_in = den_start;
         rem_in = '0;
         quo_in = '0;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         rem_in = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         quo_in = {quo_ff[CW-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         // last bit: quotient floored and kept to the register width
         if (cnt_ff == CNT_W'(1)) begin
            coef_in = {quo_ff[CW-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         coef_ff <= CW'(1) << COEF_FRAC_BITS;
      end else begin
         cnt_ff  <= cnt_in;
         coef_ff <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign coef = coef_ff;
   assign busy = (cnt_ff != '0);

endmodule

`default_nettype wire

/* src/rbca_chan_map.sv */
// ----------------------------------------------------------------------------
// rbca_chan_map
// Three-stage datapath for one channel: offset and brightness, contrast
// product, floor/clamp and mode select.
// ----------------------------------------------------------------------------
`default_nettype none

module rbca_chan_map
   import rbca_pkg::*;
#(
   parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic [PIPE_STAGES-1:0]              en,
   input  wire logic [MODE_BITS-1:0]                mode,
   input  wire logic [CH_BITS-1:0]                  level,
   input  wire logic [CH_BITS+COEF_FRAC_BITS-1:0]   coef,
   input  wire logic [CH_BITS-1:0]                  pix_in,
   output logic [CH_BITS-1:0]                       pix_out
);

   localparam int unsigned CW     = CH_BITS + COEF_FRAC_BITS;
   localparam int unsigned PROD_W = CW + CH_BITS + 2;
   localparam int unsigned Q_W    = PROD_W - COEF_FRAC_BITS;
   localparam int unsigned ST_IN  = 0;
   localparam int unsigned ST_MUL = 1;
   localparam int unsigned ST_OUT = 2;

   logic signed [CH_BITS:0]     dev_ff, dev_in;
   logic [CH_BITS-1:0]          bright1_ff, bright1_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic [CH_BITS-1:0]          bright2_ff;
   logic [CH_BITS-1:0]          out_ff, out_in;

   logic [CH_BITS:0]            sum;
   logic signed [Q_W-1:0]       quo;
   logic signed [Q_W-1:0]       res;
   logic [CH_BITS-1:0]          contrast;

   // stage 1: deviation from mid-gray and saturated brightness
   always_comb begin
      dev_in = $signed({1'b0, pix_in}) - $signed((CH_BITS+1)'(CH_MID));
      sum    = {1'b0, pix_in} + {1'b0, level};
      if (mode[MODE_LOWER_BIT]) begin
         bright1_in = (pix_in > level) ? (pix_in - level) : '0;
      end else begin
         bright1_in = sum[CH_BITS] ? CH_BITS'(CH_MAX) : sum[CH_BITS-1:0];
      end
   end

   // stage 2: signed product with the coefficient
   assign prod_in = $signed({1'b0, coef}) * dev_ff;

   // stage 3: floor (arithmetic shift), recenter, clamp, select
   always_comb begin
      quo = prod_ff[PROD_W-1:COEF_FRAC_BITS];
      res = quo + $signed(Q_W'(CH_MID));
      if (res[Q_W-1]) begin
         contrast = '0;
      end else if (res > $signed(Q_W'(CH_MAX))) begin
         contrast = CH_BITS'(CH_MAX);
      end else begin
         contrast = res[CH_BITS-1:0];
      end
      out_in = mode[MODE_CONTRAST_BIT] ? contrast : bright2_ff;
   end

   always_ff @(posedge clock) begin
      if (en[ST_IN]) begin
         dev_ff     <= dev_in;
         bright1_ff <= bright1_in;
      end
      if (en[ST_MUL]) begin
         prod_ff    <= prod_in;
         bright2_ff <= bright1_ff;
      end
      if (en[ST_OUT]) begin
         out_ff     <= out_in;
      end
   end

   assign pix_out = out_ff;

endmodule

`default_nettype wire
